/* rtl/core/int_to_chinese_numeral_unit_defines.svh */
// ---------------------------------------------------------------------------
// assertion macros for the checker file of the numeral unit
// ---------------------------------------------------------------------------
`ifndef INT_TO_CHINESE_NUMERAL_UNIT_DEFINES_SVH
`define INT_TO_CHINESE_NUMERAL_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ICN_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ICN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/icn_pkg.sv */
// ---------------------------------------------------------------------------
// icn_pkg
// Types and constants shared by the numeral unit controller and datapath.
// ---------------------------------------------------------------------------
package icn_pkg;

  // input and symbol widths
  localparam int unsigned ValueW    = 32;
  localparam int unsigned SymW      = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned CntW      = $clog2(ValueW);
  localparam int unsigned PosW      = $clog2(NumDigits);

  // symbol codes
  localparam logic [SymW-1:0] SymZero      = 4'd0;
  localparam logic [SymW-1:0] SymPlaceBase = 4'd9;   // plus place 1..3 gives ten..thousand
  localparam logic [SymW-1:0] SymGroupBase = 4'd12;  // plus group 1..2 gives wan, yi
  localparam logic [SymW-1:0] SymMinus     = 4'd15;

  // most significant digit position
  localparam logic [PosW-1:0] TopPos = PosW'(NumDigits - 1);

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSign,
    StSkip,
    StDigit,
    StPlace,
    StGroup,
    StAdv
  } icn_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic conv;
    logic shift;
    logic set_zr;
    logic clr_zr;
    logic set_any;
    logic clr_grp;
  } icn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [SymW-1:0] dig;
    logic [1:0]      place;
    logic [1:0]      grp;
    logic            rest_nz;
    logic            pos_zero;
    logic            bcd_zero;
    logic            neg;
    logic            zero_run;
    logic            any_nz;
    logic            conv_done;
  } icn_stat_t;

endpackage

/* rtl/core/icn_dpath.sv */
// ---------------------------------------------------------------------------
// icn_dpath
// Magnitude capture, shift-add-3 binary to decimal conversion and the
// digit walk register with its per-group zero and nonzero flags.
// ---------------------------------------------------------------------------
module icn_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [icn_pkg::ValueW-1:0] value_i,
  input  icn_pkg::icn_cmd_t          cmd_i,
  output icn_pkg::icn_stat_t         stat_o
);
  import icn_pkg::*;

  logic [ValueW-1:0] bin_q, bin_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic [BcdW-1:0]   bcd_adj;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              neg_q, neg_d;
  logic              zr_q, zr_d;
  logic              any_q, any_d;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
  end

  // next-state of the datapath registers
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    pos_d = pos_q;
    neg_d = neg_q;
    zr_d  = zr_q;
    any_d = any_q;
    if (cmd_i.load) begin
      neg_d = value_i[ValueW-1];
      bin_d = value_i[ValueW-1] ? (ValueW'(0) - value_i) : value_i;
      bcd_d = '0;
      cnt_d = '0;
      pos_d = TopPos;
      zr_d  = 1'b0;
      any_d = 1'b0;
    end
    if (cmd_i.conv) begin
      bcd_d = {bcd_adj[BcdW-2:0], bin_q[ValueW-1]};
      bin_d = {bin_q[ValueW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.shift) begin
      bcd_d = {bcd_q[BcdW-5:0], 4'b0000};
      pos_d = pos_q - 1'b1;
    end
    if (cmd_i.set_zr)  zr_d  = 1'b1;
    if (cmd_i.clr_zr)  zr_d  = 1'b0;
    if (cmd_i.set_any) any_d = 1'b1;
    if (cmd_i.clr_grp) begin
      zr_d  = 1'b0;
      any_d = 1'b0;
    end
  end

  // control flags and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_q <= '0;
      neg_q <= 1'b0;
      zr_q  <= 1'b0;
      any_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      neg_q <= neg_d;
      zr_q  <= zr_d;
      any_q <= any_d;
    end
  end

  // conversion registers
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  // status: current digit always sits in the top nibble
  always_comb begin
    stat_o.dig       = bcd_q[BcdW-1 -: 4];
    stat_o.place     = pos_q[1:0];
    stat_o.grp       = 2'(pos_q >> 2);
    stat_o.rest_nz   = |bcd_q[BcdW-5:0];
    stat_o.pos_zero  = (pos_q == '0);
    stat_o.bcd_zero  = (bcd_q == '0);
    stat_o.neg       = neg_q;
    stat_o.zero_run  = zr_q;
    stat_o.any_nz    = any_q;
    stat_o.conv_done = (cnt_q == '1);
  end

endmodule

/* rtl/core/icn_ctrl.sv */
// ---------------------------------------------------------------------------
// icn_ctrl
// Sequencer that runs the conversion, walks the digits from the top and
// drives one symbol per output transaction.
// ---------------------------------------------------------------------------
module icn_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [icn_pkg::SymW-1:0] symbol_o,
  output logic                     last_o,
  output icn_pkg::icn_cmd_t        cmd_o,
  input  icn_pkg::icn_stat_t       stat_i
);
  import icn_pkg::*;

  icn_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state, commands and symbol output
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    symbol_o    = SymZero;
    last_o      = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.conv = 1'b1;
        if (stat_i.conv_done) state_d = StSign;
      end
      StSign: begin
        if (stat_i.bcd_zero) begin
          out_valid_o = 1'b1;
          symbol_o    = SymZero;
          last_o      = 1'b1;
          if (out_ready_i) state_d = StIdle;
        end else if (stat_i.neg) begin
          out_valid_o = 1'b1;
          symbol_o    = SymMinus;
          if (out_ready_i) state_d = StSkip;
        end else begin
          state_d = StSkip;
        end
      end
      // drop leading zero digits
      StSkip: begin
        if (stat_i.dig == '0) begin
          cmd_o.shift = 1'b1;
        end else begin
          state_d = StDigit;
        end
      end
      StDigit: begin
        if (stat_i.dig == '0) begin
          cmd_o.set_zr = 1'b1;
          state_d      = (stat_i.place == '0) ? StGroup : StAdv;
        end else if (stat_i.zero_run) begin
          // one zero symbol for a run of zeros inside the group
          out_valid_o = 1'b1;
          symbol_o    = SymZero;
          if (out_ready_i) cmd_o.clr_zr = 1'b1;
        end else begin
          out_valid_o = 1'b1;
          symbol_o    = stat_i.dig;
          last_o      = !stat_i.rest_nz && (stat_i.place == '0) && (stat_i.grp == '0);
          if (out_ready_i) begin
            cmd_o.set_any = 1'b1;
            state_d       = (stat_i.place == '0) ? StGroup : StPlace;
          end
        end
      end
      // a group suffix still follows the place symbol outside the lowest group
      StPlace: begin
        out_valid_o = 1'b1;
        symbol_o    = SymPlaceBase + {2'b00, stat_i.place};
        last_o      = !stat_i.rest_nz && (stat_i.grp == '0);
        if (out_ready_i) state_d = StAdv;
      end
      // group suffix only after a group holding a nonzero digit
      StGroup: begin
        if ((stat_i.grp != '0) && stat_i.any_nz) begin
          out_valid_o = 1'b1;
          symbol_o    = SymGroupBase + {2'b00, stat_i.grp};
          last_o      = !stat_i.rest_nz;
          if (out_ready_i) begin
            cmd_o.clr_grp = 1'b1;
            state_d       = StAdv;
          end
        end else begin
          cmd_o.clr_grp = 1'b1;
          state_d       = StAdv;
        end
      end
      StAdv: begin
        if (stat_i.pos_zero) begin
          state_d = StIdle;
        end else begin
          cmd_o.shift = 1'b1;
          state_d     = StDigit;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

/* rtl/core/int_to_chinese_numeral_unit.sv */
// ---------------------------------------------------------------------------
// int_to_chinese_numeral_unit
// Spells a signed 32-bit integer as a run of Chinese numeral symbol codes.
// ---------------------------------------------------------------------------
// One integer is taken at a time. After acceptance, a shift-add-3 unit turns
// the magnitude into ten decimal digits; a sequencer then skips the leading
// zero digits and walks the rest from the top, and each symbol leaves on an
// output transaction of its own, at most one per cycle. The input is ready
// again once the walk has passed the lowest digit: the cycle after the final
// symbol for a zero, otherwise only after the walk has stepped through the
// remaining digit positions behind the symbol marked by last_o.
module int_to_chinese_numeral_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [icn_pkg::ValueW-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [icn_pkg::SymW-1:0]          symbol_o,
  output logic                              last_o
);
  import icn_pkg::*;

  icn_cmd_t  cmd;
  icn_stat_t stat;

  // sequencer
  icn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .symbol_o    (symbol_o),
    .last_o      (last_o),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // conversion and digit walk
  icn_dpath u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .value_i (value_i),
    .cmd_i   (cmd),
    .stat_o  (stat)
  );

endmodule

/* rtl/core/icn_checker.sv */
// ---------------------------------------------------------------------------
// icn_checker
// Port-level checks of the numeral unit, attached by bind.
// ---------------------------------------------------------------------------
`include "int_to_chinese_numeral_unit_defines.svh"

module icn_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [icn_pkg::SymW-1:0] symbol_o,
  input logic                     last_o
);

  // a stalled output transaction is held
  `ICN_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(symbol_o) && $stable(last_o), "output transaction dropped while stalled")

  // one item at a time: no input taken while symbols are offered
  `ICN_ASSERT_NOW(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o, "input ready while output valid")

  // conversion runs right after an accepted input
  `ICN_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o && !out_valid_o, "unit not busy after input transaction")

  // nothing follows the final symbol of a reading
  `ICN_ASSERT_NEXT(a_after_last, clk_i, rst_ni, out_valid_o && out_ready_i && last_o, !out_valid_o, "symbol offered after final symbol")

endmodule

bind int_to_chinese_numeral_unit icn_checker u_icn_checker (.*);

/* tb/sv/tb.sv */
// ---------------------------------------------------------------------------
// tb: self-checking bench for int_to_chinese_numeral_unit
// Feeds signed integers over the input channel and checks every symbol
// transaction against a typed or locally spelled Chinese numeral reading. A
// short directed table covers extremes and zero-handling corners, then random
// values of several shapes follow, with random gaps on both sides outside a gap-free run.
// ---------------------------------------------------------------------------
module tb;
  import icn_pkg::*;

  localparam int GroupDigits  = 4;
  localparam int RandomItems  = 200;
  localparam int CycleLimit   = 500000;
  localparam int DrainCycles  = 100;
  localparam int GapPercent   = 13;

  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            last;
  } numeral_sym_t;

  // one directed row; typed_n of zero means the speller fills in the reading
  typedef struct {
    logic [ValueW-1:0] value;
    int unsigned       typed_n;
    logic [87:0]       typed_syms;
  } directed_row_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic signed [ValueW-1:0] value_i     = '0;
  logic                     out_ready_i = 1'b0;
  logic                     in_ready_o;
  logic                     out_valid_o;
  logic [SymW-1:0]          symbol_o;
  logic                     last_o;

  numeral_sym_t  expected_syms[$];
  directed_row_t directed_rows[$];
  int            mismatches = 0;
  int            cycle_count = 0;
  logic          no_gaps = 1'b0;

  int_to_chinese_numeral_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .symbol_o   (symbol_o),
    .last_o     (last_o)
  );

  // clock, period 2
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run-length guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // spell one value and queue its symbols
  function automatic void spell_value(input logic [ValueW-1:0] v);
    logic [ValueW-1:0] mag;
    logic [SymW-1:0]   dig [NumDigits];
    int                len;
    int                groups;
    int                pos;
    int                size;
    int                place;
    logic              zero_run;
    logic              any_nz;
    numeral_sym_t      run[$];
    mag = v[ValueW-1] ? (32'd0 - v) : v;
    if (mag == 0) begin
      expected_syms.push_back('{sym: SymZero, last: 1'b1});
      return;
    end
    len = 0;
    while (mag != 0) begin
      dig[len] = 4'(mag % 10);
      mag = mag / 10;
      len++;
    end
    if (v[ValueW-1]) run.push_back('{sym: SymMinus, last: 1'b0});
    groups = (len + GroupDigits - 1) / GroupDigits;
    pos = len - 1;
    for (int g = groups - 1; g >= 0; g--) begin
      size = (g == groups - 1) ? len - (groups - 1) * GroupDigits : GroupDigits;
      zero_run = 1'b0;
      any_nz = 1'b0;
      for (int i = 0; i < size; i++) begin
        place = size - 1 - i;
        if (dig[pos] == 0) begin
          zero_run = 1'b1;
        end else begin
          // a zero run in front of a nonzero digit reads as one zero
          if (zero_run) run.push_back('{sym: SymZero, last: 1'b0});
          zero_run = 1'b0;
          any_nz = 1'b1;
          run.push_back('{sym: dig[pos], last: 1'b0});
          if (place > 0) run.push_back('{sym: SymPlaceBase + 4'(place), last: 1'b0});
        end
        pos--;
      end
      // an all-zero group gets no group suffix
      if (g > 0 && any_nz) run.push_back('{sym: SymGroupBase + 4'(g), last: 1'b0});
    end
    run[run.size() - 1].last = 1'b1;
    foreach (run[i]) expected_syms.push_back(run[i]);
  endfunction

  // typed-in reading, first symbol in the highest used nibble
  function automatic void queue_typed(input int unsigned n, input logic [87:0] syms);
    for (int i = 0; i < n; i++) begin
      expected_syms.push_back('{sym: syms[(n - 1 - i) * 4 +: 4], last: (i == n - 1)});
    end
  endfunction

  function automatic void add_row(input logic [ValueW-1:0] v, input int unsigned n,
                                  input logic [87:0] syms);
    directed_row_t row;
    row.value = v;
    row.typed_n = n;
    row.typed_syms = syms;
    directed_rows.push_back(row);
  endfunction

  // random values of several shapes
  function automatic logic [ValueW-1:0] pick_value();
    logic [63:0] acc;
    logic [ValueW-1:0] v;
    int ndig;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(9999);
      2: begin
        // decimal digits with many zeros
        ndig = $urandom_range(1, NumDigits);
        acc = 0;
        for (int i = 0; i < ndig; i++) begin
          acc = acc * 10 + (($urandom_range(1) == 0) ? 0 : $urandom_range(1, 9));
        end
        if (acc > 64'd2147483648) acc = acc % 64'd2147483648;
        v = acc[ValueW-1:0];
      end
      3: v = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                               : 32'h8000_0000 + $urandom_range(3);
      4: begin
        // one digit times a power of ten
        acc = $urandom_range(1, 9);
        ndig = $urandom_range(0, NumDigits - 2);
        for (int i = 0; i < ndig; i++) acc = acc * 10;
        v = acc[ValueW-1:0];
      end
      default: v = $urandom;
    endcase
    if (v != 32'h8000_0000 && $urandom_range(2) == 0) v = 32'd0 - v;
    return v;
  endfunction

  // one input transaction, starting at a falling edge
  task automatic send_value(input logic [ValueW-1:0] v, input int unsigned n,
                            input logic [87:0] syms);
    while (!no_gaps && $urandom_range(99) < GapPercent) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    if (n == 0) spell_value(v);
    else queue_typed(n, syms);
    @(negedge clk_i);
  endtask

  // output side ready, with random stalls
  always @(negedge clk_i) begin
    out_ready_i <= no_gaps ? 1'b1 : ($urandom_range(99) >= GapPercent);
  end

  // compare each symbol transaction with the oldest expectation
  always @(posedge clk_i) begin
    numeral_sym_t exp_sym;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_syms.size() == 0) begin
        $display("%0t unexpected symbol: expected none actual symbol %0d last %0d",
                 $time, symbol_o, last_o);
        mismatches++;
      end else begin
        exp_sym = expected_syms.pop_front();
        if (symbol_o !== exp_sym.sym) begin
          $display("%0t symbol mismatch: expected %0d actual %0d", $time, exp_sym.sym,
                   symbol_o);
          mismatches++;
        end
        if (last_o !== exp_sym.last) begin
          $display("%0t last mismatch: expected %0d actual %0d", $time, exp_sym.last,
                   last_o);
          mismatches++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    // directed rows: typed readings for zero, units, group corners and extremes, then rows for the speller
    add_row(32'd0, 1, 88'h0);
    add_row(32'd1, 1, 88'h1);
    add_row(-32'sd1, 2, 88'hF1);
    add_row(32'd10, 2, 88'h1A);
    add_row(32'd10001, 4, 88'h1D01);
    add_row(32'd100000001, 4, 88'h1E01);
    add_row(32'd2147483647, 19, 88'h2A1E4C7B4A8D3C6B4A7);
    add_row(32'h8000_0000, 20, 88'hF2A1E4C7B4A8D3C6B4A8);
    add_row(32'd9, 0, '0);
    add_row(32'd11, 0, '0);
    add_row(32'd19, 0, '0);
    add_row(32'd101, 0, '0);
    add_row(32'd110, 0, '0);
    add_row(32'd1001, 0, '0);
    add_row(32'd1010, 0, '0);
    add_row(32'd9999, 0, '0);
    add_row(32'd100000, 0, '0);
    add_row(32'd20000000, 0, '0);
    add_row(32'd99999999, 0, '0);
    add_row(32'd1000000000, 0, '0);
    add_row(32'd1000000010, 0, '0);
    add_row(32'd1234567890, 0, '0);
    add_row(-32'sd1000000000, 0, '0);
    add_row(-32'sd2147483647, 0, '0);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_value(directed_rows[i].value, directed_rows[i].typed_n,
                 directed_rows[i].typed_syms);
    end

    // hold off until the output side has drained
    in_valid_i <= 1'b0;
    while (expected_syms.size() != 0) @(negedge clk_i);

    for (int i = 0; i < RandomItems; i++) begin
      no_gaps <= (i >= 80 && i < 140);
      send_value(pick_value(), 0, '0);
    end
    in_valid_i <= 1'b0;

    while (expected_syms.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && expected_syms.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
